@@ sv/dckvs_pkg.sv @@
// dckvs_pkg: shared constants, codes and types of the key velocity scanner
// used by every module of the scanner but the ram, and by the bench; depends on nothing

package dckvs_pkg;

  // matrix geometry and timer width
  localparam int COLUMNS      = 8;
  localparam int KEYS_PER_COL = 8;
  localparam int TIMER_BITS   = 16;

  // fixed field widths of the word ports
  localparam int COL_W     = 3;
  localparam int BITS_W    = 16;
  localparam int KEY_OUT_W = 6;
  localparam int ELAPSED_W = 16;

  // key state store covers 64 keys, one row per column code
  localparam int KEY_SLOTS = 64;
  localparam int COL_SLOTS = 2 ** COL_W;
  localparam int KEY_W     = 8;
  localparam int ROW_IDX_W = (KEYS_PER_COL > 1) ? $clog2(KEYS_PER_COL) : 1;

  // operation codes of the input word
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // event kinds of the output word
  localparam logic EV_NOTE_ON  = 1'b0;
  localparam logic EV_NOTE_OFF = 1'b1;

  // contact codes, bit 0 top contact, bit 1 bottom contact
  localparam logic [1:0] CT_NONE = 2'b00;
  localparam logic [1:0] CT_TOP  = 2'b01;
  localparam logic [1:0] CT_BOTH = 2'b11;

  // per key phase of the press / release sequence
  typedef enum logic [1:0] {
    PH_WAIT_TOP = 2'd0,
    PH_INITIAL  = 2'd1,
    PH_WAIT_OFF = 2'd2,
    PH_FINAL    = 2'd3
  } phase_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LANE = 2'd1,
    ST_EMIT = 2'd2
  } ctrl_state_e;

  // one key's stored state
  typedef struct packed {
    logic [1:0]            contacts;
    phase_e                phase;
    logic [TIMER_BITS-1:0] stamp;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);
  localparam int ROW_W   = KEYS_PER_COL * ENTRY_W;

  // event found by one lane
  typedef struct packed {
    logic                  valid;
    logic                  kind;
    logic [TIMER_BITS-1:0] elapsed;
  } lane_evt_t;

  // control from the sequencer to the merge stage
  typedef struct packed {
    logic             load;
    logic [COL_W-1:0] column;
  } merge_ctrl_t;

  // status from the merge stage to the sequencer
  typedef struct packed {
    logic pend_any;
  } merge_stat_t;

endpackage

@@ sv/dckvs_ram.sv @@
// dckvs_ram: generic single write port, single read port ram with registered read
// depends on nothing

module dckvs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/dckvs_lane.sv @@
// dckvs_lane: four-phase transition table for one key of the scanned column
// depends on dckvs_pkg

module dckvs_lane (
  input  logic                            en_i,
  input  logic [1:0]                      contacts_i,
  input  dckvs_pkg::key_entry_t           entry_i,
  input  logic [dckvs_pkg::TIMER_BITS-1:0] tick_i,
  output dckvs_pkg::key_entry_t           entry_o,
  output dckvs_pkg::lane_evt_t            evt_o
);

  // transition table, only for a key whose contacts changed
  always_comb begin
    entry_o         = entry_i;
    evt_o.valid     = 1'b0;
    evt_o.kind      = dckvs_pkg::EV_NOTE_ON;
    evt_o.elapsed   = tick_i - entry_i.stamp;
    if (en_i && (contacts_i != entry_i.contacts)) begin
      entry_o.contacts = contacts_i;
      case (entry_i.phase)
        dckvs_pkg::PH_WAIT_TOP: begin
          if (contacts_i == dckvs_pkg::CT_TOP) begin
            entry_o.stamp = tick_i;
            entry_o.phase = dckvs_pkg::PH_INITIAL;
          end else if (contacts_i == dckvs_pkg::CT_BOTH) begin
            // fast hit, no event
            entry_o.phase = dckvs_pkg::PH_WAIT_OFF;
          end
        end
        dckvs_pkg::PH_INITIAL: begin
          if (contacts_i == dckvs_pkg::CT_NONE) begin
            entry_o.stamp = tick_i;
            entry_o.phase = dckvs_pkg::PH_WAIT_TOP;
          end else if (contacts_i == dckvs_pkg::CT_BOTH) begin
            entry_o.phase = dckvs_pkg::PH_WAIT_OFF;
            evt_o.valid   = 1'b1;
            evt_o.kind    = dckvs_pkg::EV_NOTE_ON;
          end
        end
        dckvs_pkg::PH_WAIT_OFF: begin
          if (contacts_i == dckvs_pkg::CT_TOP) begin
            entry_o.stamp = tick_i;
            entry_o.phase = dckvs_pkg::PH_FINAL;
          end else if (contacts_i == dckvs_pkg::CT_NONE) begin
            // quick release, no event
            entry_o.phase = dckvs_pkg::PH_WAIT_TOP;
          end
        end
        dckvs_pkg::PH_FINAL: begin
          if (contacts_i == dckvs_pkg::CT_BOTH) begin
            // re-press, no event
            entry_o.phase = dckvs_pkg::PH_WAIT_OFF;
          end else if (contacts_i == dckvs_pkg::CT_NONE) begin
            entry_o.phase = dckvs_pkg::PH_WAIT_TOP;
            evt_o.valid   = 1'b1;
            evt_o.kind    = dckvs_pkg::EV_NOTE_OFF;
          end
        end
        default: begin
          entry_o.phase = entry_i.phase;
        end
      endcase
    end
  end

endmodule

@@ sv/dckvs_merge.sv @@
// dckvs_merge: collects the lane events of one column and sends them out in row order
// depends on dckvs_pkg; holds the output word register

module dckvs_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dckvs_pkg::merge_ctrl_t           ctrl_i,
  input  dckvs_pkg::lane_evt_t             evt_i [dckvs_pkg::KEYS_PER_COL],
  output dckvs_pkg::merge_stat_t           stat_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             event_kind_o,
  output logic [dckvs_pkg::KEY_OUT_W-1:0]  key_number_o,
  output logic [dckvs_pkg::ELAPSED_W-1:0]  elapsed_ticks_o,
  output logic                             last_of_run_o
);

  logic [dckvs_pkg::KEYS_PER_COL-1:0]  pend_q, pend_d;
  logic [dckvs_pkg::KEYS_PER_COL-1:0]  kind_q;
  logic [dckvs_pkg::TIMER_BITS-1:0]    elapsed_q [dckvs_pkg::KEYS_PER_COL];
  logic [dckvs_pkg::COL_W-1:0]         col_q;
  logic                                out_valid_q, out_valid_d;
  logic                                kind_out_q;
  logic [dckvs_pkg::KEY_OUT_W-1:0]     key_out_q;
  logic [dckvs_pkg::ELAPSED_W-1:0]     elapsed_out_q;
  logic                                last_out_q;

  logic                                sel_found;
  logic [dckvs_pkg::ROW_IDX_W-1:0]     sel_idx;
  logic [dckvs_pkg::KEYS_PER_COL-1:0]  sel_mask;
  logic [dckvs_pkg::KEYS_PER_COL-1:0]  remaining;
  logic [dckvs_pkg::KEY_W-1:0]         sel_key;
  logic                                issue;

  // lowest pending row goes first
  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    for (int i = 0; i < dckvs_pkg::KEYS_PER_COL; i++) begin
      if (pend_q[i] && !sel_found) begin
        sel_found = 1'b1;
        sel_idx   = dckvs_pkg::ROW_IDX_W'(i);
      end
    end
    sel_mask          = '0;
    sel_mask[sel_idx] = sel_found;
    remaining         = pend_q & ~sel_mask;
  end

  // key number of the selected row
  assign sel_key = dckvs_pkg::KEY_W'(col_q)
                 + dckvs_pkg::KEY_W'(sel_idx) * dckvs_pkg::KEY_W'(dckvs_pkg::COLUMNS);

  // output register takes a word when empty or when its word leaves
  assign issue = sel_found && (!out_valid_q || !out_stall_i);

  // pending mask and output valid
  always_comb begin
    if (ctrl_i.load) begin
      for (int i = 0; i < dckvs_pkg::KEYS_PER_COL; i++) begin
        pend_d[i] = evt_i[i].valid;
      end
    end else if (issue) begin
      pend_d = remaining;
    end else begin
      pend_d = pend_q;
    end
    if (issue) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // event buffer of the current column
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      col_q <= ctrl_i.column;
      for (int i = 0; i < dckvs_pkg::KEYS_PER_COL; i++) begin
        kind_q[i]    <= evt_i[i].kind;
        elapsed_q[i] <= evt_i[i].elapsed;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      kind_out_q    <= kind_q[sel_idx];
      key_out_q     <= sel_key[dckvs_pkg::KEY_OUT_W-1:0];
      elapsed_out_q <= dckvs_pkg::ELAPSED_W'(elapsed_q[sel_idx]);
      last_out_q    <= (remaining == '0);
    end
  end

  assign stat_o.pend_any = |pend_q;
  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_out_q;
  assign key_number_o    = key_out_q;
  assign elapsed_ticks_o = elapsed_out_q;
  assign last_of_run_o   = last_out_q;

endmodule

@@ sv/dual_contact_key_velocity_scanner.sv @@
// Dual contact key velocity scanner. A tick word advances the wrapping timestamp counter.
// A scan word reads the column's row of key state from an eight-row memory, runs one
// transition lane per key row in the next cycle, writes the row back and hands the
// events to the merge stage, which sends one event word per cycle while the output is
// not stalled, in increasing row order through a single output register. A scan word
// holds the input side through its lane cycle and, if it gives events, until all of
// them have entered the output register; the single output register sets the one event
// per cycle. Each memory row has a valid flag cleared by reset, so no clearing pass is
// needed after reset. Columns at or above the column count are dropped without effect.
// depends on dckvs_pkg, dckvs_ram, dckvs_lane and dckvs_merge

module dual_contact_key_velocity_scanner (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [dckvs_pkg::COL_W-1:0]      column_i,
  input  logic [dckvs_pkg::BITS_W-1:0]     column_bits_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             event_kind_o,
  output logic [dckvs_pkg::KEY_OUT_W-1:0]  key_number_o,
  output logic [dckvs_pkg::ELAPSED_W-1:0]  elapsed_ticks_o,
  output logic                             last_of_run_o
);

  dckvs_pkg::ctrl_state_e             state_q, state_d;
  logic [dckvs_pkg::TIMER_BITS-1:0]   tick_q;
  logic [dckvs_pkg::COL_SLOTS-1:0]    row_valid_q;
  logic                               rd_valid_q;
  logic [dckvs_pkg::COL_W-1:0]        col_q;
  logic [dckvs_pkg::BITS_W-1:0]       bits_q;

  logic                               in_accept;
  logic                               col_ok;
  logic                               scan_start;
  logic                               lane_cycle;
  logic                               any_evt;
  logic [dckvs_pkg::ROW_W-1:0]        rd_row;
  logic [dckvs_pkg::ROW_W-1:0]        wr_row;
  logic [dckvs_pkg::KEYS_PER_COL-1:0] evt_valid;

  dckvs_pkg::lane_evt_t               lane_evt [dckvs_pkg::KEYS_PER_COL];
  dckvs_pkg::merge_ctrl_t             merge_ctrl;
  dckvs_pkg::merge_stat_t             merge_stat;

  // input handshake
  assign in_accept  = in_valid_i && !in_stall_o;
  assign col_ok     = ({29'd0, column_i} < 32'(dckvs_pkg::COLUMNS));
  assign scan_start = in_accept && (operation_i == dckvs_pkg::OP_SCAN) && col_ok;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dckvs_pkg::ST_IDLE: begin
        if (scan_start) begin
          state_d = dckvs_pkg::ST_LANE;
        end
      end
      dckvs_pkg::ST_LANE: begin
        state_d = any_evt ? dckvs_pkg::ST_EMIT : dckvs_pkg::ST_IDLE;
      end
      dckvs_pkg::ST_EMIT: begin
        if (!merge_stat.pend_any) begin
          state_d = dckvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dckvs_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    lane_cycle = 1'b0;
    case (state_q)
      dckvs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      dckvs_pkg::ST_LANE: begin
        lane_cycle = 1'b1;
      end
      dckvs_pkg::ST_EMIT: begin
        in_stall_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dckvs_pkg::ST_IDLE;
      tick_q      <= '0;
      row_valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept && (operation_i == dckvs_pkg::OP_TICK)) begin
        tick_q <= tick_q + 1'b1;
      end
      if (lane_cycle) begin
        row_valid_q[col_q] <= 1'b1;
      end
    end
  end

  // scan word capture
  always_ff @(posedge clk_i) begin
    if (scan_start) begin
      col_q      <= column_i;
      bits_q     <= column_bits_i;
      rd_valid_q <= row_valid_q[column_i];
    end
  end

  // key state memory, one row per column
  dckvs_ram #(
    .WIDTH (dckvs_pkg::ROW_W),
    .DEPTH (dckvs_pkg::COL_SLOTS)
  ) u_state_ram (
    .clk_i     (clk_i),
    .wr_en_i   (lane_cycle),
    .wr_addr_i (col_q),
    .wr_data_i (wr_row),
    .rd_en_i   (scan_start),
    .rd_addr_i (column_i),
    .rd_data_o (rd_row)
  );

  // one lane per key row
  for (genvar r = 0; r < dckvs_pkg::KEYS_PER_COL; r++) begin : g_lane
    dckvs_pkg::key_entry_t       cur_entry;
    dckvs_pkg::key_entry_t       nxt_entry;
    logic [dckvs_pkg::KEY_W-1:0] key;
    logic                        key_ok;

    assign cur_entry = rd_valid_q
                     ? dckvs_pkg::key_entry_t'(rd_row[r*dckvs_pkg::ENTRY_W +: dckvs_pkg::ENTRY_W])
                     : dckvs_pkg::key_entry_t'('0);
    assign key    = dckvs_pkg::KEY_W'(col_q) + dckvs_pkg::KEY_W'(r * dckvs_pkg::COLUMNS);
    assign key_ok = (key < dckvs_pkg::KEY_W'(dckvs_pkg::KEY_SLOTS));

    dckvs_lane u_lane (
      .en_i       (key_ok),
      .contacts_i (bits_q[2*r +: 2]),
      .entry_i    (cur_entry),
      .tick_i     (tick_q),
      .entry_o    (nxt_entry),
      .evt_o      (lane_evt[r])
    );

    assign wr_row[r*dckvs_pkg::ENTRY_W +: dckvs_pkg::ENTRY_W] = nxt_entry;
    assign evt_valid[r] = lane_evt[r].valid;
  end

  assign any_evt = |evt_valid;

  // merge stage and output register
  assign merge_ctrl.load   = lane_cycle;
  assign merge_ctrl.column = col_q;

  dckvs_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (merge_ctrl),
    .evt_i           (lane_evt),
    .stat_o          (merge_stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .key_number_o    (key_number_o),
    .elapsed_ticks_o (elapsed_ticks_o),
    .last_of_run_o   (last_of_run_o)
  );

`ifndef NO_ASSERTIONS
  // pending events exist only while the sequencer is emitting
  a_pend_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_stat.pend_any |-> (state_q == dckvs_pkg::ST_EMIT))
    else $error("pending events outside emit state");

  // the lane state with its write back never follows itself
  a_lane_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dckvs_pkg::ST_LANE) |=> (state_q != dckvs_pkg::ST_LANE))
    else $error("lane cycle repeated");

  // an accepted tick advances the counter by one
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (operation_i == dckvs_pkg::OP_TICK)) |=> (tick_q == $past(tick_q) + 1'b1))
    else $error("tick counter did not advance");
`endif

endmodule

@@ bench/tb_dual_contact_key_velocity_scanner.sv @@
// tb_dual_contact_key_velocity_scanner: self-checking bench for the key velocity scanner
// sends tick and column scan words, predicts note events and checks every event word
// depends on dckvs_pkg and dual_contact_key_velocity_scanner

module tb_dual_contact_key_velocity_scanner;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int IDLE_PCT     = 34;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 330;
  localparam int LONG_TICKS   = 12;

  // one pending stimulus word; hold marks a pause until all events are out
  typedef struct packed {
    logic                         hold;
    logic                         op;
    logic [dckvs_pkg::COL_W-1:0]  col;
    logic [dckvs_pkg::BITS_W-1:0] bits;
  } scan_word_t;

  // one event word as it leaves the scanner
  typedef struct packed {
    logic                            kind;
    logic [dckvs_pkg::KEY_OUT_W-1:0] key;
    logic [dckvs_pkg::ELAPSED_W-1:0] ticks;
    logic                            last_run;
  } note_t;

  logic                             clk_i;
  logic                             rst_ni        = 1'b0;
  logic                             in_valid_i    = 1'b0;
  logic                             in_stall_o;
  logic                             operation_i   = dckvs_pkg::OP_TICK;
  logic [dckvs_pkg::COL_W-1:0]      column_i      = '0;
  logic [dckvs_pkg::BITS_W-1:0]     column_bits_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i   = 1'b0;
  logic                             event_kind_o;
  logic [dckvs_pkg::KEY_OUT_W-1:0]  key_number_o;
  logic [dckvs_pkg::ELAPSED_W-1:0]  elapsed_ticks_o;
  logic                             last_of_run_o;

  // stimulus and expected events
  scan_word_t word_q[$];
  note_t      due_events[$];
  scan_word_t next_word;
  note_t      got_event;
  note_t      want_event;

  // predicted key state
  logic [1:0]                       contact_mem [dckvs_pkg::KEY_SLOTS];
  dckvs_pkg::phase_e                phase_mem   [dckvs_pkg::KEY_SLOTS];
  logic [dckvs_pkg::TIMER_BITS-1:0] stamp_mem   [dckvs_pkg::KEY_SLOTS];
  logic [dckvs_pkg::TIMER_BITS-1:0] tick_count;

  // contacts as the stimulus generator believes them
  logic [1:0] gen_pair [dckvs_pkg::KEY_SLOTS];
  bit         gen_down [dckvs_pkg::KEY_SLOTS];

  int  fail_cnt    = 0;
  int  words_taken = 0;
  int  cycle_cnt   = 0;
  bit  word_taken  = 1'b0;
  bit  steady      = 1'b0;

  dual_contact_key_velocity_scanner uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .column_i        (column_i),
    .column_bits_i   (column_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .key_number_o    (key_number_o),
    .elapsed_ticks_o (elapsed_ticks_o),
    .last_of_run_o   (last_of_run_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // key state update for one accepted word, queues the events it causes
  task automatic advance_keys(input logic op, input logic [dckvs_pkg::COL_W-1:0] col,
                              input logic [dckvs_pkg::BITS_W-1:0] bits);
    int                               key;
    int                               found;
    logic [1:0]                       pair;
    logic                             fire;
    logic                             kind;
    logic [dckvs_pkg::TIMER_BITS-1:0] gap;
    note_t                            ev;
    found = 0;
    if (op == dckvs_pkg::OP_TICK) begin
      tick_count = tick_count + 1'b1;
    end else if (int'(col) < dckvs_pkg::COLUMNS) begin
      for (int row = 0; row < dckvs_pkg::KEYS_PER_COL; row++) begin
        key  = int'(col) + row * dckvs_pkg::COLUMNS;
        pair = bits[2*row +: 2];
        if (key < dckvs_pkg::KEY_SLOTS && contact_mem[key] != pair) begin
          contact_mem[key] = pair;
          fire = 1'b0;
          kind = dckvs_pkg::EV_NOTE_ON;
          gap  = tick_count - stamp_mem[key];
          case (phase_mem[key])
            dckvs_pkg::PH_WAIT_TOP: begin
              if (pair == dckvs_pkg::CT_TOP) begin
                stamp_mem[key] = tick_count;
                phase_mem[key] = dckvs_pkg::PH_INITIAL;
              end else if (pair == dckvs_pkg::CT_BOTH) begin
                // fast hit, both contacts seen at once
                phase_mem[key] = dckvs_pkg::PH_WAIT_OFF;
              end
            end
            dckvs_pkg::PH_INITIAL: begin
              if (pair == dckvs_pkg::CT_NONE) begin
                stamp_mem[key] = tick_count;
                phase_mem[key] = dckvs_pkg::PH_WAIT_TOP;
              end else if (pair == dckvs_pkg::CT_BOTH) begin
                fire = 1'b1;
                phase_mem[key] = dckvs_pkg::PH_WAIT_OFF;
              end
            end
            dckvs_pkg::PH_WAIT_OFF: begin
              if (pair == dckvs_pkg::CT_TOP) begin
                stamp_mem[key] = tick_count;
                phase_mem[key] = dckvs_pkg::PH_FINAL;
              end else if (pair == dckvs_pkg::CT_NONE) begin
                // quick release, no event
                phase_mem[key] = dckvs_pkg::PH_WAIT_TOP;
              end
            end
            default: begin
              if (pair == dckvs_pkg::CT_BOTH) begin
                // re-press before full release
                phase_mem[key] = dckvs_pkg::PH_WAIT_OFF;
              end else if (pair == dckvs_pkg::CT_NONE) begin
                fire = 1'b1;
                kind = dckvs_pkg::EV_NOTE_OFF;
                phase_mem[key] = dckvs_pkg::PH_WAIT_TOP;
              end
            end
          endcase
          if (fire) begin
            ev.kind     = kind;
            ev.key      = dckvs_pkg::KEY_OUT_W'(key);
            ev.ticks    = dckvs_pkg::ELAPSED_W'(gap);
            ev.last_run = 1'b0;
            due_events.push_back(ev);
            found++;
          end
        end
      end
    end
    if (found > 0) due_events[due_events.size()-1].last_run = 1'b1;
  endtask

  task automatic put_tick(input int count);
    scan_word_t w;
    for (int n = 0; n < count; n++) begin
      // payload of a tick is don't-care, keep it moving
      w.hold = 1'b0;
      w.op   = dckvs_pkg::OP_TICK;
      w.col  = dckvs_pkg::COL_W'($urandom());
      w.bits = dckvs_pkg::BITS_W'($urandom());
      word_q.push_back(w);
    end
  endtask

  task automatic put_scan(input int col, input logic [dckvs_pkg::BITS_W-1:0] bits);
    scan_word_t w;
    w.hold = 1'b0;
    w.op   = dckvs_pkg::OP_SCAN;
    w.col  = dckvs_pkg::COL_W'(col);
    w.bits = bits;
    word_q.push_back(w);
  endtask

  task automatic put_hold();
    scan_word_t w;
    w = '0;
    w.hold = 1'b1;
    word_q.push_back(w);
  endtask

  // mostly press / release cycles per key, some noise words and ticks
  task automatic put_random_words(input int count);
    int                           pick;
    int                           col;
    int                           key;
    int                           roll;
    logic [1:0]                   pair;
    logic [dckvs_pkg::BITS_W-1:0] bits;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) put_hold();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        put_tick(1);
      end else begin
        col  = $urandom_range(0, dckvs_pkg::COLUMNS - 1);
        bits = dckvs_pkg::BITS_W'($urandom());
        if (pick >= 45) begin
          for (int row = 0; row < dckvs_pkg::KEYS_PER_COL; row++) begin
            key  = col + row * dckvs_pkg::COLUMNS;
            pair = gen_pair[key];
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
              pair = 2'($urandom());
            end else if (roll < 50) begin
              case (pair)
                dckvs_pkg::CT_NONE: begin
                  pair = dckvs_pkg::CT_TOP;
                  gen_down[key] = 1'b1;
                end
                dckvs_pkg::CT_TOP: begin
                  if (gen_down[key]) pair = dckvs_pkg::CT_BOTH;
                  else pair = dckvs_pkg::CT_NONE;
                  gen_down[key] = 1'b0;
                end
                dckvs_pkg::CT_BOTH: pair = dckvs_pkg::CT_TOP;
                default: pair = dckvs_pkg::CT_NONE;
              endcase
            end
            bits[2*row +: 2] = pair;
          end
        end
        for (int row = 0; row < dckvs_pkg::KEYS_PER_COL; row++) begin
          gen_pair[col + row * dckvs_pkg::COLUMNS] = bits[2*row +: 2];
        end
        put_scan(col, bits);
      end
    end
  endtask

  // accept side: prediction on input words, checking of event words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken = in_valid_i && !in_stall_o;
      if (word_taken) begin
        advance_keys(operation_i, column_i, column_bits_i);
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        got_event.kind     = event_kind_o;
        got_event.key      = key_number_o;
        got_event.ticks    = elapsed_ticks_o;
        got_event.last_run = last_of_run_o;
        if (due_events.size() == 0) begin
          $error("event word with no event due: key_number %0d", got_event.key);
          fail_cnt++;
        end else begin
          want_event = due_events.pop_front();
          if (got_event.kind != want_event.kind) begin
            $error("event_kind: expected %0d, actual %0d", want_event.kind, got_event.kind);
            fail_cnt++;
          end
          if (got_event.key != want_event.key) begin
            $error("key_number: expected %0d, actual %0d", want_event.key, got_event.key);
            fail_cnt++;
          end
          if (got_event.ticks != want_event.ticks) begin
            $error("elapsed_ticks: expected %0d, actual %0d", want_event.ticks,
                   got_event.ticks);
            fail_cnt++;
          end
          if (got_event.last_run != want_event.last_run) begin
            $error("last_of_run: expected %0d, actual %0d", want_event.last_run,
                   got_event.last_run);
            fail_cnt++;
          end
        end
      end
    end
  end

  // drive side: next word from the queue, random gaps and output stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      steady = (words_taken >= 120 && words_taken < 200);
      if (!in_valid_i || word_taken) begin
        if (word_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (word_q[0].hold) begin
          // pause until every due event has been seen
          in_valid_i <= 1'b0;
          if (due_events.size() == 0) word_q.delete(0);
        end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
          in_valid_i <= 1'b0;
        end else begin
          next_word = word_q.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= next_word.op;
          column_i      <= next_word.col;
          column_bits_i <= next_word.bits;
        end
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus plan, reset and end of run
  initial begin
    for (int k = 0; k < dckvs_pkg::KEY_SLOTS; k++) begin
      contact_mem[k] = dckvs_pkg::CT_NONE;
      phase_mem[k]   = dckvs_pkg::PH_WAIT_TOP;
      stamp_mem[k]   = '0;
      gen_pair[k]    = dckvs_pkg::CT_NONE;
      gen_down[k]    = 1'b0;
    end
    tick_count = '0;

    // single key press and release with timing
    put_scan(0, 16'h0001);
    put_tick(3);
    put_scan(0, 16'h0003);
    put_tick(1);
    put_scan(0, 16'h0001);
    put_tick(2);
    put_scan(0, 16'h0000);
    // whole column at once, eight events on the both-contact word and on the release word, highest key number
    put_scan(7, 16'h5555);
    put_tick(1);
    put_scan(7, 16'hFFFF);
    put_scan(7, 16'h5555);
    put_scan(7, 16'h0000);
    // fast hit then quick release
    put_scan(1, 16'h0003);
    put_scan(1, 16'h0000);
    // bottom contact alone is outside the table
    put_scan(2, 16'hAAAA);
    // top contact dropped before bottom
    put_scan(3, 16'h0001);
    put_scan(3, 16'h0000);
    // re-press from final contact, unchanged pair, quick release
    put_scan(4, 16'h0001);
    put_scan(4, 16'h0003);
    put_scan(4, 16'h0001);
    put_scan(4, 16'h0003);
    put_scan(4, 16'h0003);
    put_scan(4, 16'h0000);
    put_hold();

    put_random_words(RANDOM_WORDS);

    // long press over many ticks on two keys
    put_scan(5, 16'h0000);
    put_scan(6, 16'h0000);
    put_scan(5, 16'h4000);
    put_tick(LONG_TICKS);
    put_scan(6, 16'h0001);
    put_tick(3);
    put_scan(5, 16'hC000);
    put_scan(6, 16'h0003);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || in_valid_i || due_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_events.size() != 0) begin
      $error("%0d events due but never sent", due_events.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dckvs_pkg.sv
sv/dckvs_ram.sv
sv/dckvs_lane.sv
sv/dckvs_merge.sv
sv/dual_contact_key_velocity_scanner.sv
bench/tb_dual_contact_key_velocity_scanner.sv
